// ===== hw/rtl/hsc_pkg.sv =====
`timescale 1ns / 1ps
package hsc_pkg;

    // operation codes on the command channel
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RAPID = 2'd1;
    localparam logic [1:0] OP_FEED  = 2'd2;

    // register indexes on the configuration channel
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_STEP_X   = 3'd2;
    localparam logic [2:0] REG_STEP_Y   = 3'd3;
    localparam logic [2:0] REG_COLUMNS  = 3'd4;
    localparam logic [2:0] REG_ROWS     = 3'd5;
    localparam logic [2:0] REG_HEIGHT   = 3'd6;

    // divider geometry: Q16.16 offset shifted left by 16 over a 31-bit step
    localparam int DIV_DW = 49;
    localparam int DIV_SW = 31;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
    localparam logic signed [34:0] S32_MIN = -35'sd2147483648;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [30:0]        step_x;     // never zero
        logic [30:0]        step_y;
        logic [5:0]         cols;       // capped at the grid size
        logic [5:0]         rows;
        logic signed [31:0] height_ref;
    } geom_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [31:0]        feed_rate;
        logic [4:0]         cell_column;
        logic [4:0]         cell_row;
        logic signed [31:0] cell_height;
        logic signed [31:0] height_rel;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quot;
        logic [DIV_SW-1:0] rem;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end
        else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/hsc_cmd_if.sv =====
`timescale 1ns / 1ps
interface hsc_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [31:0]        feed_rate;
    logic [4:0]         cell_column;
    logic [4:0]         cell_row;
    logic signed [31:0] cell_height;

    modport source (output valid, operation, target_x, target_y, target_z, feed_rate,
                    cell_column, cell_row, cell_height, input ready);
    modport sink (input valid, operation, target_x, target_y, target_z, feed_rate,
                  cell_column, cell_row, cell_height, output ready);
endinterface

// ===== hw/rtl/hsc_point_if.sv =====
`timescale 1ns / 1ps
interface hsc_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               out_rapid;
    logic [31:0]        out_feed;
    logic               out_last;

    modport source (output valid, out_x, out_y, out_z, out_rapid, out_feed, out_last,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, out_rapid, out_feed, out_last,
                  output ready);
endinterface

// ===== hw/rtl/hsc_cfg_if.sv =====
`timescale 1ns / 1ps
interface hsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/heightmap_segment_compensator_core.sv =====
`timescale 1ns / 1ps
// Order: a rapid passes the queue, the RAPID state and the output register; a feed runs
// five divisions (NX, NY, DX, DY, DZ), then per segment STEP, two divisions (FX, FY), four
// RD/MUL/ACC terms, FIN and OUT. The back end takes no new command until it is done with the last;
// every division runs on the single shared 49-step divider.
// Reset: asynchronous, active low; afterwards the height grid is cleared one cell a cycle
// and no command beat is taken meanwhile.
module heightmap_segment_compensator_core #(
    parameter int MAX_COLUMNS  = 32,
    parameter int MAX_ROWS     = 32,
    parameter int MAX_SEGMENTS = 64
) (
    input logic         clk,
    input logic         rst_n,
    hsc_cmd_if.sink     cmd,
    hsc_point_if.source point,
    hsc_cfg_if.sink     cfg
);
    import hsc_pkg::*;

    // configuration registers: the user writes them only while the block is quiet; the block does not enforce it
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [30:0]        step_x_reg;
    logic [30:0]        step_y_reg;
    logic [5:0]         columns_reg;
    logic [5:0]         rows_reg;
    logic signed [31:0] height_ref_reg;

    geom_t    geom;
    logic     clearing;
    logic     push_valid;
    logic     push_ready;
    item_t    push_data;
    logic     pop_valid;
    logic     pop_ready;
    item_t    pop_data;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            step_x_reg     <= 31'd65536;
            step_y_reg     <= 31'd65536;
            columns_reg    <= 6'd32;
            rows_reg       <= 6'd32;
            height_ref_reg <= '0;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                REG_ORIGIN_X: origin_x_reg   <= cfg.data;
                REG_ORIGIN_Y: origin_y_reg   <= cfg.data;
                REG_STEP_X:   step_x_reg     <= cfg.data[30:0];
                REG_STEP_Y:   step_y_reg     <= cfg.data[30:0];
                REG_COLUMNS:  columns_reg    <= cfg.data[5:0];
                REG_ROWS:     rows_reg       <= cfg.data[5:0];
                REG_HEIGHT:   height_ref_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // effective geometry: a zero step acts as one LSB, cell counts capped at the grid size
    always_comb
    begin
        geom.origin_x   = origin_x_reg;
        geom.origin_y   = origin_y_reg;
        geom.step_x     = (step_x_reg == '0) ? 31'd1 : step_x_reg;
        geom.step_y     = (step_y_reg == '0) ? 31'd1 : step_y_reg;
        geom.cols       = (32'(columns_reg) < MAX_COLUMNS) ? columns_reg : 6'(MAX_COLUMNS);
        geom.rows       = (32'(rows_reg) < MAX_ROWS) ? rows_reg : 6'(MAX_ROWS);
        geom.height_ref = height_ref_reg;
    end

    // front: classify beats, drop off-grid loads and unused codes
    hsc_front u_front (
        .cmd        (cmd),
        .geom       (geom),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back: grid store, segment walk, bilinear lift, result register
    hsc_back #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .clearing  (clearing),
        .point     (point)
    );

`ifndef ASSERT_OFF
    a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(cmd.valid && cmd.ready))
        else $error("command beat taken during grid clear");

    a_no_point_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !point.valid)
        else $error("point shown during grid clear");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_rapid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.out_rapid) |-> point.out_last)
        else $error("rapid point not marked last");
`endif
endmodule

// ===== hw/rtl/hsc_div.sv =====
`timescale 1ns / 1ps
module hsc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  hsc_pkg::div_req_t req,
    output hsc_pkg::div_rsp_t rsp
);
    import hsc_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_SW:0]   rem_reg;
    logic [DIV_SW-1:0] dsr_reg;

    logic [DIV_SW:0] shifted;
    logic            ge;
    logic [DIV_SW:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg[DIV_SW-1:0], quo_reg[DIV_DW-1]};
        ge       = shifted >= {1'b0, dsr_reg};
        rem_next = ge ? shifted - {1'b0, dsr_reg} : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(DIV_DW);
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_DW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg[DIV_SW-1:0];
endmodule

// ===== hw/rtl/hsc_queue.sv =====
`timescale 1ns / 1ps
module hsc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  hsc_pkg::item_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output hsc_pkg::item_t pop_data
);
    import hsc_pkg::*;

    // two-entry FIFO between classifier and executor
    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/hsc_front.sv =====
`timescale 1ns / 1ps
module hsc_front (
    hsc_cmd_if.sink        cmd,
    input  hsc_pkg::geom_t geom,
    input  logic           clearing,
    output logic           push_valid,
    input  logic           push_ready,
    output hsc_pkg::item_t push_data
);
    import hsc_pkg::*;

    logic accept;
    logic in_grid;
    logic keep;

    assign cmd.ready = !clearing && push_ready;
    assign accept    = cmd.valid && cmd.ready;
    assign in_grid   = ({1'b0, cmd.cell_column} < geom.cols) && ({1'b0, cmd.cell_row} < geom.rows);

    // loads off the grid and unused codes are dropped here
    always_comb
    begin
        case (cmd.operation)
            OP_LOAD:  keep = in_grid;
            OP_RAPID: keep = 1'b1;
            OP_FEED:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign push_valid = accept && keep;

    always_comb
    begin
        push_data.op          = cmd.operation;
        push_data.target_x    = cmd.target_x;
        push_data.target_y    = cmd.target_y;
        push_data.target_z    = cmd.target_z;
        push_data.feed_rate   = cmd.feed_rate;
        push_data.cell_column = cmd.cell_column;
        push_data.cell_row    = cmd.cell_row;
        push_data.cell_height = cmd.cell_height;
        push_data.height_rel  = sat32(35'(cmd.cell_height) - 35'(geom.height_ref));
    end
endmodule

// ===== hw/rtl/hsc_back.sv =====
`timescale 1ns / 1ps
module hsc_back #(
    parameter int MAX_COLUMNS  = 32,
    parameter int MAX_ROWS     = 32,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hsc_pkg::geom_t    geom,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  hsc_pkg::item_t    pop_data,
    output hsc_pkg::div_req_t div_req,
    input  hsc_pkg::div_rsp_t div_rsp,
    output logic              clearing,
    hsc_point_if.source       point
);
    import hsc_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_SEGMENTS + 1);

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_RAPID = 5'd2;
    localparam logic [4:0] ST_NX    = 5'd3;
    localparam logic [4:0] ST_NY    = 5'd4;
    localparam logic [4:0] ST_DX    = 5'd5;
    localparam logic [4:0] ST_DY    = 5'd6;
    localparam logic [4:0] ST_DZ    = 5'd7;
    localparam logic [4:0] ST_STEP  = 5'd8;
    localparam logic [4:0] ST_FX    = 5'd9;
    localparam logic [4:0] ST_FY    = 5'd10;
    localparam logic [4:0] ST_RD    = 5'd11;
    localparam logic [4:0] ST_MUL   = 5'd12;
    localparam logic [4:0] ST_ACC   = 5'd13;
    localparam logic [4:0] ST_FIN   = 5'd14;
    localparam logic [4:0] ST_OUT   = 5'd15;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // floor quotient from magnitude quotient and remainder
    function automatic logic signed [49:0] floor_q(input logic neg, input logic [48:0] q,
                                                   input logic [30:0] r);
        logic signed [49:0] qs;
        qs = signed'({1'b0, q});
        if (neg) begin
            qs = (r != '0) ? -qs - 50'sd1 : -qs;
        end
        return qs;
    endfunction

    // one segment of floor(dd*k/n), kept as quotient plus remainder
    function automatic logic [31+NW:0] advance(input logic signed [31:0] acc,
                                               input logic [NW-1:0] rm,
                                               input logic signed [33:0] qs,
                                               input logic [NW-1:0] rs,
                                               input logic [NW-1:0] n);
        logic [NW:0]        sum;
        logic               carry;
        logic signed [33:0] a;
        sum   = {1'b0, rm} + {1'b0, rs};
        carry = sum >= {1'b0, n};
        a     = 34'(acc) + qs + (carry ? 34'sd1 : 34'sd0);
        return {a[31:0], carry ? NW'(sum - {1'b0, n}) : NW'(sum)};
    endfunction

    logic [4:0]   state_reg;
    logic [4:0]   state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic         div_started_reg;

    logic signed [31:0] max_height_reg;
    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic signed [31:0] prev_z_reg;

    item_t              cur_reg;
    logic signed [32:0] ddx_reg;
    logic signed [32:0] ddy_reg;
    logic signed [32:0] ddz_reg;
    logic [DIV_DW-1:0]  qx_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      k_reg;
    logic signed [33:0] qs_x_reg;
    logic signed [33:0] qs_y_reg;
    logic signed [33:0] qs_z_reg;
    logic [NW-1:0]      rs_x_reg;
    logic [NW-1:0]      rs_y_reg;
    logic [NW-1:0]      rs_z_reg;
    logic signed [31:0] acc_x_reg;
    logic signed [31:0] acc_y_reg;
    logic signed [31:0] acc_z_reg;
    logic [NW-1:0]      rm_x_reg;
    logic [NW-1:0]      rm_y_reg;
    logic [NW-1:0]      rm_z_reg;
    logic signed [49:0] fx_reg;
    logic signed [49:0] fy_reg;
    logic [1:0]         term_reg;
    logic [33:0]        w_reg;
    logic               ok_reg;
    logic signed [66:0] prod_reg;
    logic signed [66:0] sum_reg;
    logic signed [31:0] z_reg;

    logic               ovalid_reg;
    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;
    logic signed [31:0] oz_reg;
    logic               orapid_reg;
    logic [31:0]        ofeed_reg;
    logic               olast_reg;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;

    logic               out_free;
    logic               out_we;
    logic               is_last;
    logic               div_state;
    logic signed [32:0] dxo;
    logic signed [32:0] dyo;
    logic signed [31:0] rapid_z;
    logic [AW-1:0]      load_addr;
    logic signed [33:0] fxq;
    logic signed [33:0] fyq;
    logic               step_i;
    logic               step_j;
    logic signed [34:0] ci;
    logic signed [34:0] cj;
    logic               cell_ok;
    logic [AW-1:0]      rd_addr;
    logic [16:0]        wx;
    logic [16:0]        wy;
    logic [DIV_DW-1:0]  qmax;
    logic signed [66:0] rnd;
    logic signed [34:0] dz;
    logic [31+NW:0]     adv_x;
    logic [31+NW:0]     adv_y;
    logic [31+NW:0]     adv_z;

    assign clearing  = state_reg == ST_CLEAR;
    assign out_free  = !ovalid_reg || point.ready;
    assign is_last   = k_reg == n_reg;
    assign dxo       = 33'(acc_x_reg) - 33'(geom.origin_x);
    assign dyo       = 33'(acc_y_reg) - 33'(geom.origin_y);
    assign rapid_z   = sat32(35'(cur_reg.target_z) + 35'(max_height_reg));
    assign load_addr = AW'(32'(pop_data.cell_row) * MAX_COLUMNS + 32'(pop_data.cell_column));
    assign div_state = (state_reg == ST_NX) || (state_reg == ST_NY) || (state_reg == ST_DX) ||
                       (state_reg == ST_DY) || (state_reg == ST_DZ) || (state_reg == ST_FX) ||
                       (state_reg == ST_FY);

    // bilinear corner for the current term: 0 (i,j) 1 (i+1,j) 2 (i+1,j+1) 3 (i,j+1)
    assign fxq     = fx_reg[49:16];
    assign fyq     = fy_reg[49:16];
    assign step_i  = (term_reg == 2'd1) || (term_reg == 2'd2);
    assign step_j  = (term_reg == 2'd2) || (term_reg == 2'd3);
    assign ci      = 35'(fxq) + (step_i ? 35'sd1 : 35'sd0);
    assign cj      = 35'(fyq) + (step_j ? 35'sd1 : 35'sd0);
    assign cell_ok = !ci[34] && (ci[33:0] < 34'(geom.cols)) &&
                     !cj[34] && (cj[33:0] < 34'(geom.rows));
    assign rd_addr = AW'(32'(cj[RW-1:0]) * MAX_COLUMNS + 32'(ci[CW-1:0]));
    assign wx      = step_i ? {1'b0, fx_reg[15:0]} : Q16_ONE - {1'b0, fx_reg[15:0]};
    assign wy      = step_j ? {1'b0, fy_reg[15:0]} : Q16_ONE - {1'b0, fy_reg[15:0]};

    assign qmax  = (qx_reg > div_rsp.quot) ? qx_reg : div_rsp.quot;
    assign rnd   = sum_reg + (67'sd1 <<< 31);
    assign dz    = rnd[66:32];
    assign adv_x = advance(acc_x_reg, rm_x_reg, qs_x_reg, rs_x_reg, n_reg);
    assign adv_y = advance(acc_y_reg, rm_y_reg, qs_y_reg, rs_y_reg, n_reg);
    assign adv_z = advance(acc_z_reg, rm_z_reg, qs_z_reg, rs_z_reg, n_reg);

    always_comb
    begin
        state_next          = state_reg;
        pop_ready           = 1'b0;
        mem_we              = 1'b0;
        mem_addr            = clr_cnt_reg;
        mem_wdata           = '0;
        out_we              = 1'b0;
        div_req.start       = div_state && !div_started_reg;
        div_req.dividend    = '0;
        div_req.divisor     = geom.step_x;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    case (pop_data.op)
                        OP_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = load_addr;
                            mem_wdata = pop_data.height_rel;
                        end
                        OP_RAPID: state_next = ST_RAPID;
                        OP_FEED:  state_next = ST_NX;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RAPID:
            begin
                if (out_free) begin
                    out_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NX:
            begin
                div_req.dividend = DIV_DW'(abs33(ddx_reg));
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_NY;
                end
            end
            ST_NY:
            begin
                div_req.dividend = DIV_DW'(abs33(ddy_reg));
                div_req.divisor  = geom.step_y;
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_DX;
                end
            end
            ST_DX:
            begin
                div_req.dividend = DIV_DW'(abs33(ddx_reg));
                div_req.divisor  = DIV_SW'(n_reg);
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_DY;
                end
            end
            ST_DY:
            begin
                div_req.dividend = DIV_DW'(abs33(ddy_reg));
                div_req.divisor  = DIV_SW'(n_reg);
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_DZ;
                end
            end
            ST_DZ:
            begin
                div_req.dividend = DIV_DW'(abs33(ddz_reg));
                div_req.divisor  = DIV_SW'(n_reg);
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: state_next = ST_FX;
            ST_FX:
            begin
                div_req.dividend = {abs33(dxo), 16'd0};
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_FY;
                end
            end
            ST_FY:
            begin
                div_req.dividend = {abs33(dyo), 16'd0};
                div_req.divisor  = geom.step_y;
                if (div_started_reg && div_rsp.done) begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                mem_addr   = rd_addr;
                state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: state_next = (term_reg == 2'd3) ? ST_FIN : ST_RD;
            ST_FIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free) begin
                    out_we     = 1'b1;
                    state_next = is_last ? ST_IDLE : ST_STEP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            div_started_reg <= 1'b0;
            ovalid_reg      <= 1'b0;
            max_height_reg  <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_z_reg      <= '0;
        end
        else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (div_req.start) begin
                div_started_reg <= 1'b1;
            end
            else if (div_rsp.done) begin
                div_started_reg <= 1'b0;
            end
            if (out_we) begin
                ovalid_reg <= 1'b1;
            end
            else if (point.ready) begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && pop_valid && pop_data.op == OP_LOAD &&
                pop_data.cell_height > max_height_reg) begin
                max_height_reg <= pop_data.cell_height;
            end
            if (state_reg == ST_RAPID && out_free) begin
                prev_x_reg <= cur_reg.target_x;
                prev_y_reg <= cur_reg.target_y;
                prev_z_reg <= rapid_z;
            end
            // a feed leaves the uncompensated target behind
            if (state_reg == ST_OUT && out_free && is_last) begin
                prev_x_reg <= cur_reg.target_x;
                prev_y_reg <= cur_reg.target_y;
                prev_z_reg <= cur_reg.target_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid) begin
                    cur_reg <= pop_data;
                    ddx_reg <= 33'(pop_data.target_x) - 33'(prev_x_reg);
                    ddy_reg <= 33'(pop_data.target_y) - 33'(prev_y_reg);
                    ddz_reg <= 33'(pop_data.target_z) - 33'(prev_z_reg);
                end
            end
            ST_NX:
            begin
                if (div_started_reg && div_rsp.done) begin
                    qx_reg <= div_rsp.quot;
                end
            end
            ST_NY:
            begin
                if (div_started_reg && div_rsp.done) begin
                    n_reg     <= (qmax >= DIV_DW'(MAX_SEGMENTS - 1)) ? NW'(MAX_SEGMENTS)
                                                                    : NW'(qmax + DIV_DW'(1));
                    k_reg     <= '0;
                    acc_x_reg <= prev_x_reg;
                    acc_y_reg <= prev_y_reg;
                    acc_z_reg <= prev_z_reg;
                    rm_x_reg  <= '0;
                    rm_y_reg  <= '0;
                    rm_z_reg  <= '0;
                end
            end
            ST_DX:
            begin
                if (div_started_reg && div_rsp.done) begin
                    qs_x_reg <= 34'(floor_q(ddx_reg[32], div_rsp.quot, div_rsp.rem));
                    rs_x_reg <= (ddx_reg[32] && div_rsp.rem != '0) ?
                                NW'(DIV_SW'(n_reg) - div_rsp.rem) : NW'(div_rsp.rem);
                end
            end
            ST_DY:
            begin
                if (div_started_reg && div_rsp.done) begin
                    qs_y_reg <= 34'(floor_q(ddy_reg[32], div_rsp.quot, div_rsp.rem));
                    rs_y_reg <= (ddy_reg[32] && div_rsp.rem != '0) ?
                                NW'(DIV_SW'(n_reg) - div_rsp.rem) : NW'(div_rsp.rem);
                end
            end
            ST_DZ:
            begin
                if (div_started_reg && div_rsp.done) begin
                    qs_z_reg <= 34'(floor_q(ddz_reg[32], div_rsp.quot, div_rsp.rem));
                    rs_z_reg <= (ddz_reg[32] && div_rsp.rem != '0) ?
                                NW'(DIV_SW'(n_reg) - div_rsp.rem) : NW'(div_rsp.rem);
                end
            end
            ST_STEP:
            begin
                acc_x_reg <= adv_x[31+NW:NW];
                rm_x_reg  <= adv_x[NW-1:0];
                acc_y_reg <= adv_y[31+NW:NW];
                rm_y_reg  <= adv_y[NW-1:0];
                acc_z_reg <= adv_z[31+NW:NW];
                rm_z_reg  <= adv_z[NW-1:0];
                k_reg     <= k_reg + NW'(1);
            end
            ST_FX:
            begin
                if (div_started_reg && div_rsp.done) begin
                    fx_reg <= floor_q(dxo[32], div_rsp.quot, div_rsp.rem);
                end
            end
            ST_FY:
            begin
                if (div_started_reg && div_rsp.done) begin
                    fy_reg   <= floor_q(dyo[32], div_rsp.quot, div_rsp.rem);
                    term_reg <= '0;
                    sum_reg  <= '0;
                end
            end
            ST_RD:
            begin
                w_reg  <= 34'(wx) * 34'(wy);
                ok_reg <= cell_ok;
            end
            ST_MUL:
            begin
                prod_reg <= 67'(signed'({1'b0, w_reg})) *
                            67'(ok_reg ? signed'(rdata_reg) : 32'sd0);
            end
            ST_ACC:
            begin
                sum_reg  <= sum_reg + prod_reg;
                term_reg <= term_reg + 2'd1;
            end
            ST_FIN:
            begin
                z_reg <= sat32(35'(acc_z_reg) + dz);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_we) begin
            if (state_reg == ST_RAPID) begin
                ox_reg     <= cur_reg.target_x;
                oy_reg     <= cur_reg.target_y;
                oz_reg     <= rapid_z;
                orapid_reg <= 1'b1;
                ofeed_reg  <= '0;
                olast_reg  <= 1'b1;
            end
            else begin
                ox_reg     <= acc_x_reg;
                oy_reg     <= acc_y_reg;
                oz_reg     <= z_reg;
                orapid_reg <= 1'b0;
                ofeed_reg  <= cur_reg.feed_rate;
                olast_reg  <= is_last;
            end
        end
    end

    assign point.valid     = ovalid_reg;
    assign point.out_x     = ox_reg;
    assign point.out_y     = oy_reg;
    assign point.out_z     = oz_reg;
    assign point.out_rapid = orapid_reg;
    assign point.out_feed  = ofeed_reg;
    assign point.out_last  = olast_reg;
endmodule

// ===== tb/hsc_point_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the compensator: mirrors grid, config and last position,
// predicts every emitted point and compares it on the point channel.
module hsc_point_checker
    import hsc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    hsc_cmd_if   cmd,
    hsc_point_if point,
    hsc_cfg_if   cfg,
    output int   errors,
    output int   pending,
    output int   points_seen,
    output int   feeds_seen,
    output int   rapids_seen,
    output int   loads_seen
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               rapid;
        logic [31:0]        feed;
        logic               last;
    } point_t;

    point_t expected_points[$];

    longint org_x, org_y, hgt_ref, stp_x, stp_y, n_cols, n_rows;
    longint heights[1024];
    longint peak, at_x, at_y, at_z;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
        begin
            q--;
        end
        return q;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint grid_height(longint i, longint j);
        longint c, r;
        c = (n_cols < 32) ? n_cols : 32;
        r = (n_rows < 32) ? n_rows : 32;
        if (i < 0 || j < 0 || i >= c || j >= r)
        begin
            return 0;
        end
        return heights[j * 32 + i];
    endfunction

    function automatic logic signed [95:0] wide(longint v);
        logic signed [95:0] w;
        w = v;
        return w;
    endfunction

    // bilinear lift at (x,y), rounded half up
    function automatic longint surface_lift(longint x, longint y);
        longint sx, sy, ox, oy, q, p, tq, uq;
        logic signed [95:0] acc;
        sx = (stp_x != 0) ? stp_x : 1;
        sy = (stp_y != 0) ? stp_y : 1;
        ox = x - org_x;
        oy = y - org_y;
        q  = floor_div(ox, sx);
        p  = floor_div(oy, sy);
        tq = ((ox - q * sx) * 65536) / sx;
        uq = ((oy - p * sy) * 65536) / sy;
        acc = wide((65536 - tq) * (65536 - uq)) * wide(grid_height(q, p));
        acc = acc + wide(tq * (65536 - uq)) * wide(grid_height(q + 1, p));
        acc = acc + wide(tq * uq) * wide(grid_height(q + 1, p + 1));
        acc = acc + wide((65536 - tq) * uq) * wide(grid_height(q, p + 1));
        acc = acc + wide(64'sd2147483648);
        acc = acc >>> 32;
        return longint'(acc[63:0]);
    endfunction

    task automatic check_point();
        point_t e;
        if (expected_points.size() == 0)
        begin
            if (errors < 10)
            begin
                $display("unexpected point x=%h y=%h z=%h", point.out_x, point.out_y,
                         point.out_z);
            end
            errors++;
            return;
        end
        e = expected_points.pop_front();
        if (e.x !== point.out_x || e.y !== point.out_y || e.z !== point.out_z ||
            e.rapid !== point.out_rapid || e.feed !== point.out_feed ||
            e.last !== point.out_last)
        begin
            if (errors < 10)
            begin
                $display("point mismatch exp x=%h y=%h z=%h r=%b f=%h l=%b",
                         e.x, e.y, e.z, e.rapid, e.feed, e.last);
                $display("               got x=%h y=%h z=%h r=%b f=%h l=%b",
                         point.out_x, point.out_y, point.out_z, point.out_rapid,
                         point.out_feed, point.out_last);
            end
            errors++;
        end
    endtask

    task automatic predict_move();
        longint tx, ty, tz, dx, dy, dz, n, qx, qy, cx, cy, cz, sx, sy;
        point_t e;
        tx = longint'(cmd.target_x);
        ty = longint'(cmd.target_y);
        tz = longint'(cmd.target_z);
        case (cmd.operation)
            OP_LOAD:
            begin
                loads_seen++;
                if (cmd.cell_column < n_cols && cmd.cell_row < n_rows)
                begin
                    heights[cmd.cell_row * 32 + cmd.cell_column] =
                        clamp32(longint'(cmd.cell_height) - hgt_ref);
                    if (longint'(cmd.cell_height) > peak)
                    begin
                        peak = longint'(cmd.cell_height);
                    end
                end
            end
            OP_RAPID:
            begin
                rapids_seen++;
                e.x = tx[31:0];
                e.y = ty[31:0];
                cz = clamp32(tz + peak);
                e.z = cz[31:0];
                e.rapid = 1'b1;
                e.feed = '0;
                e.last = 1'b1;
                expected_points.push_back(e);
                at_x = tx;
                at_y = ty;
                at_z = cz;
            end
            OP_FEED:
            begin
                feeds_seen++;
                sx = (stp_x != 0) ? stp_x : 1;
                sy = (stp_y != 0) ? stp_y : 1;
                dx = tx - at_x;
                dy = ty - at_y;
                dz = tz - at_z;
                qx = ((dx < 0) ? -dx : dx) / sx;
                qy = ((dy < 0) ? -dy : dy) / sy;
                n = ((qx > qy) ? qx : qy) + 1;
                if (n > 64)
                begin
                    n = 64;
                end
                for (longint k = 1; k <= n; k++)
                begin
                    cx = at_x + floor_div(dx * k, n);
                    cy = at_y + floor_div(dy * k, n);
                    cz = clamp32(at_z + floor_div(dz * k, n) + surface_lift(cx, cy));
                    e.x = cx[31:0];
                    e.y = cy[31:0];
                    e.z = cz[31:0];
                    e.rapid = 1'b0;
                    e.feed = cmd.feed_rate;
                    e.last = (k == n);
                    expected_points.push_back(e);
                end
                at_x = tx;
                at_y = ty;
                at_z = tz;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_points.delete();
            foreach (heights[i])
            begin
                heights[i] = 0;
            end
            peak = 0;
            at_x = 0;
            at_y = 0;
            at_z = 0;
            org_x = 0;
            org_y = 0;
            hgt_ref = 0;
            stp_x = 65536;
            stp_y = 65536;
            n_cols = 32;
            n_rows = 32;
            errors = 0;
            points_seen = 0;
            feeds_seen = 0;
            rapids_seen = 0;
            loads_seen = 0;
        end
        else
        begin
            if (point.valid && point.ready)
            begin
                points_seen++;
                check_point();
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ORIGIN_X: org_x = longint'($signed(cfg.data));
                    REG_ORIGIN_Y: org_y = longint'($signed(cfg.data));
                    REG_STEP_X:   stp_x = longint'(cfg.data[30:0]);
                    REG_STEP_Y:   stp_y = longint'(cfg.data[30:0]);
                    REG_COLUMNS:  n_cols = longint'(cfg.data[5:0]);
                    REG_ROWS:     n_rows = longint'(cfg.data[5:0]);
                    REG_HEIGHT:   hgt_ref = longint'($signed(cfg.data));
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_move();
            end
        end
        pending = expected_points.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict. The checker beside the DUT does all prediction and
// comparison; this module only drives commands/config and stalls the output.
module tb_top;
    import hsc_pkg::*;

    // spare opcode, must be swallowed without output
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    hsc_cmd_if   cmd();
    hsc_point_if point();
    hsc_cfg_if   cfg();

    int errors, pending, points_seen, feeds_seen, rapids_seen, loads_seen;
    int sent;           // command beats issued
    int burst_left;     // beats left in the current back-to-back burst
    bit no_gaps;        // phase without sender idling
    int stall_mode;
    int mode_left;

    // mirror of the grid config, used only to aim stimulus at the grid
    longint aim_org_x, aim_org_y, aim_stp_x, aim_stp_y, aim_cols, aim_rows;

    heightmap_segment_compensator_core dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd.sink),
        .point(point.source),
        .cfg  (cfg.sink)
    );

    hsc_point_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .point      (point),
        .cfg        (cfg),
        .errors     (errors),
        .pending    (pending),
        .points_seen(points_seen),
        .feeds_seen (feeds_seen),
        .rapids_seen(rapids_seen),
        .loads_seen (loads_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop: sized for every feed at 64 segments under heavy stalls
    initial
    begin
        #60_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // point sink: modes change at random intervals - always ready,
    // light stalls, heavy stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.ready <= 1'b0;
            stall_mode  <= 0;
            mode_left   <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 300);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       point.ready <= 1'b1;
                1:       point.ready <= ($urandom_range(0, 3) != 0);
                default: point.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // one command beat; valid stays up on return so a following beat with
    // no gap needs no second assignment in the same step
    task automatic send_cmd(logic [1:0] op, logic [31:0] tx, logic [31:0] ty,
                            logic [31:0] tz, logic [31:0] fr, logic [4:0] col,
                            logic [4:0] row, logic [31:0] ht);
        int gap;
        gap = 0;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 8);
            end
            else
            begin
                burst_left--;
            end
        end
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.operation   <= op;
        cmd.target_x    <= tx;
        cmd.target_y    <= ty;
        cmd.target_z    <= tz;
        cmd.feed_rate   <= fr;
        cmd.cell_column <= col;
        cmd.cell_row    <= row;
        cmd.cell_height <= ht;
        @(posedge clk);
        while (!cmd.ready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold commands until every point is out, plus slack for a trailing load;
    // wait first so that the checker has booked the last accepted beat
    task automatic drain();
        int guard;
        guard = 0;
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 2_000_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
                            logic [31:0] sy, logic [31:0] nc, logic [31:0] nr,
                            logic [31:0] href);
        drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_COLUMNS, nc);
        write_reg(REG_ROWS, nr);
        write_reg(REG_HEIGHT, href);
        aim_org_x = longint'($signed(ox));
        aim_org_y = longint'($signed(oy));
        aim_stp_x = longint'(sx[30:0]);
        aim_stp_y = longint'(sy[30:0]);
        aim_cols  = longint'(nc[5:0]);
        aim_rows  = longint'(nr[5:0]);
    endtask

    // coordinate spread over the grid and one step past each edge
    function automatic logic [31:0] aim(longint org, longint stp, longint cnt);
        longint span;
        span = (cnt + 2) * stp;
        if (span > 64'd2_000_000_000 || span < 1)
        begin
            return $urandom;
        end
        return 32'(org - stp + longint'($urandom_range(0, int'(span))));
    endfunction

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
            begin
                // mostly inside the grid, sometimes beyond it
                send_cmd(OP_LOAD, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(0, 4) == 0) ? 5'($urandom)
                                                     : 5'($urandom_range(0, aim_cols - 1)),
                         ($urandom_range(0, 4) == 0) ? 5'($urandom)
                                                     : 5'($urandom_range(0, aim_rows - 1)),
                         ($urandom_range(0, 3) == 0) ? $urandom
                                                     : 32'($urandom_range(0, 262144)) - 32'd131072);
            end
            else if (r < 30)
            begin
                send_cmd(OP_RAPID, aim(aim_org_x, aim_stp_x, aim_cols),
                         aim(aim_org_y, aim_stp_y, aim_rows),
                         32'($urandom_range(0, 1_000_000)) - 32'd500_000,
                         $urandom, $urandom, $urandom, $urandom);
            end
            else if (r < 92)
            begin
                send_cmd(OP_FEED, aim(aim_org_x, aim_stp_x, aim_cols),
                         aim(aim_org_y, aim_stp_y, aim_rows),
                         32'($urandom_range(0, 1_000_000)) - 32'd500_000,
                         $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                // raw noise over every field, spare opcode included
                send_cmd(2'($urandom), $urandom, $urandom, $urandom, $urandom,
                         5'($urandom), 5'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        sent       = 0;
        burst_left = 0;
        no_gaps    = 1'b0;
        aim_org_x  = 0;
        aim_org_y  = 0;
        aim_stp_x  = 65536;
        aim_stp_y  = 65536;
        aim_cols   = 32;
        aim_rows   = 32;
        cmd.valid       <= 1'b0;
        cmd.operation   <= OP_LOAD;
        cmd.target_x    <= '0;
        cmd.target_y    <= '0;
        cmd.target_z    <= '0;
        cmd.feed_rate   <= '0;
        cmd.cell_column <= '0;
        cmd.cell_row    <= '0;
        cmd.cell_height <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_ORIGIN_X;
        cfg.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset config: corner cells at the height extremes,
        // spare opcode, outside-grid reads, zero-length and saturated feeds
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd0, 5'd0, 32'h7fffffff);
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd31, 5'd31, 32'h80000000);
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd1, 5'd0, 32'h00018000);
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd2, 5'd3, 32'hfffe0000);
        send_cmd(OP_SPARE, $urandom, $urandom, $urandom, $urandom, 5'd3, 5'd3, $urandom);
        send_cmd(OP_RAPID, 32'h00028000, 32'h00038000, 32'h00010000, 32'hdeadbeef,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'h00034000, 32'h0001c000, 32'h00002000, 32'h00001234,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'h00034000, 32'h0001c000, 32'h00002000, 32'hffffffff,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'h00004000, 32'h00008000, 32'h7fff0000, 32'h00000001,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'hffff0000, 32'hffff0000, 32'h80000000, 32'h00000010,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h55555555,
                 '0, '0, '0);
        send_cmd(OP_RAPID, 32'h80000000, 32'h7fffffff, 32'h7fffffff, '0, '0, '0, '0);
        send_cmd(OP_FEED, 32'h001f0000, 32'h001f0000, 32'h80000000, 32'haaaaaaaa,
                 '0, '0, '0);
        send_cmd(OP_FEED, 32'h001e8000, 32'h001e8000, '0, 32'h00000100, '0, '0, '0);
        send_cmd(OP_RAPID, '0, '0, 32'h80000000, '0, '0, '0, '0);

        // small grid: loads past the edge are dropped
        set_grid(32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'd4, 32'd3, 32'h00010000);
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd31, 5'd0, 32'h7fffffff);
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd0, 5'd31, 32'h7fffffff);
        send_cmd(OP_LOAD, '0, '0, '0, '0, 5'd3, 5'd2, 32'h00030000);
        random_phase(50);

        // sender never idles here
        no_gaps = 1'b1;
        set_grid(32'hfffa8000, 32'h00074000, 32'h00008000, 32'h00030000, 32'd32, 32'd32,
                 32'hfffe0000);
        random_phase(40);
        no_gaps = 1'b0;

        // extreme registers: widest step, single cell, lowest reference
        set_grid(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd1, 32'd1,
                 32'h80000000);
        random_phase(35);

        // tiny step: feeds run at high segment counts, long ones saturate
        set_grid(32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000001, 32'd32, 32'd32,
                 32'h7fffffff);
        random_phase(8);

        set_grid(32'h00020000, 32'hfffe0000, 32'h00024000, 32'h00011000, 32'd9, 32'd17,
                 32'h00004000);
        random_phase(70);

        drain();
        repeat (300) @(posedge clk);

        $display("%0d commands: %0d loads, %0d rapids, %0d feeds; %0d points checked",
                 sent, loads_seen, rapids_seen, feeds_seen, points_seen);
        $display("%0d mismatches, %0d points still owed", errors, pending);
        if (errors == 0 && pending == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
